@@ hw/rtl/waveform_table_sample_generator_unit_assert.svh @@
// assertion macros for the waveform table sample generator checker
// expects clk and rst_n in the scope where a macro is used
`ifndef WAVEFORM_TABLE_SAMPLE_GENERATOR_UNIT_ASSERT_SVH
`define WAVEFORM_TABLE_SAMPLE_GENERATOR_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define WTSG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtsg: same-cycle check failed");

// consequent checked in the next cycle
`define WTSG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wtsg: next-cycle check failed");

`endif

@@ hw/rtl/wtsg_pkg.sv @@
// types and constants for the waveform table sample generator
// no dependencies
package wtsg_pkg;

    localparam int unsigned IDX_W      = 11;
    localparam int unsigned AMP_W      = 12;
    localparam int unsigned PER_W      = 12;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    localparam int unsigned NUM_W  = 35;
    localparam int unsigned QUO_W  = 24;
    localparam int unsigned REM_W  = 12;
    localparam int unsigned LIN_W  = 13;
    localparam int unsigned CODE_W = 16;
    localparam int unsigned R_W    = 23;
    localparam int unsigned T_W    = 31;
    localparam int unsigned T2_W   = 32;
    localparam int unsigned P_W    = 64;
    localparam int unsigned MAG_W  = 17;
    localparam int unsigned OPD_W  = 18;
    localparam int unsigned HM_W   = 30;
    localparam int unsigned SV_W   = 31;

    // pipeline stage positions
    localparam int unsigned NSTG        = 23;
    localparam int unsigned DIV_STAGES  = 6;
    localparam int unsigned DIV_STEPS   = 4;
    localparam int unsigned ST_PHASE    = 7;
    localparam int unsigned ST_T        = 8;
    localparam int unsigned ST_T2       = 9;
    localparam int unsigned ST_P0       = 10;
    localparam int unsigned SERIES_TERMS = 5;
    localparam int unsigned ST_PROD     = 19;
    localparam int unsigned ST_ROUND    = 20;
    localparam int unsigned ST_MUL      = 21;
    localparam int unsigned ST_OUT      = 22;

    localparam logic [AMP_W-1:0] AMP_RESET    = 12'd4095;
    localparam logic [PER_W-1:0] PERIOD_RESET = 12'd2048;
    localparam logic [LIN_W-1:0] MIDPOINT     = 13'd2047;
    localparam logic signed [SV_W-1:0] MIDPOINT_Q15 = 31'sd67076096;

    localparam logic [T_W-1:0]   HALF_PI_Q30  = 31'd1686629713;
    localparam logic [T_W-1:0]   Q30_ONE      = 31'h4000_0000;
    localparam logic [QUO_W-1:0] QUARTER_TURN = 24'h40_0000;
    localparam logic [MAG_W-1:0] ONE_Q15      = 17'd32768;
    localparam logic [T2_W:0]    ROUND_HALF   = 33'd16384;

    // series divisors 110, 72, 42, 20, 6 as a power of two times an odd factor,
    // the odd factor done by reciprocal multiply (exact for dividends below 2^31)
    localparam int unsigned STEP_SHIFT [SERIES_TERMS] = '{1, 3, 1, 2, 1};
    localparam int unsigned STEP_K     [SERIES_TERMS] = '{37, 35, 36, 34, 33};
    localparam logic [31:0] STEP_M [SERIES_TERMS] = '{
        32'(((64'd1 << 37) + 64'd54) / 64'd55),
        32'(((64'd1 << 35) + 64'd8) / 64'd9),
        32'(((64'd1 << 36) + 64'd20) / 64'd21),
        32'(((64'd1 << 34) + 64'd4) / 64'd5),
        32'(((64'd1 << 33) + 64'd2) / 64'd3)
    };

    typedef enum logic [1:0] {
        SHAPE_SINE      = 2'd0,
        SHAPE_HAVERSINE = 2'd1,
        SHAPE_TRIANGLE  = 2'd2,
        SHAPE_SAWTOOTH  = 2'd3
    } shape_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAPE     = 2'd0,
        REG_AMPLITUDE = 2'd1,
        REG_PERIOD    = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic                    oor;
        logic [REM_W-1:0]        rem;
        logic [QUO_W-1:0]        low;
        logic [R_W-1:0]          r;
        logic                    neg;
        logic [LIN_W-1:0]        lin;
        logic [T_W-1:0]          t;
        logic [T2_W-1:0]         t2;
        logic [T2_W-1:0]         y;
        logic [P_W-1:0]          p;
        logic signed [OPD_W-1:0] m;
        logic signed [HM_W-1:0]  hm;
        logic [CODE_W-1:0]       code;
    } stage_t;

endpackage

@@ hw/rtl/waveform_table_sample_generator_unit.sv @@
// Waveform table sample generator: maps a sample index within one period to a DAC code
// for sine, haversine, triangle or sawtooth at the configured amplitude and period.
// Depends on wtsg_pkg.
//
// One sample request is taken every clock when the output side does not stall. The pipeline
// holds the index/period divider (six stages of four quotient bits) and the sine series,
// five multiply and reciprocal pairs each split over two stages. A stall on the result
// side only holds stages that are full, so bubbles close up. The user must keep the
// configuration static while requests are in flight; the block does not enforce it.
module waveform_table_sample_generator_unit #(
    parameter int MAX_PERIOD = 2048,
    parameter int DAC_BITS   = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [wtsg_pkg::IDX_W-1:0]         sample_index,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [DAC_BITS-1:0]                dac_code,
    output logic                               index_out_of_range,
    input  logic                               cfg_write,
    input  logic [wtsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wtsg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import wtsg_pkg::*;

    localparam logic [CODE_W-1:0] DAC_MAX    = CODE_W'((32'd1 << DAC_BITS) - 32'd1);
    localparam logic [PER_W-1:0]  PERIOD_CAP = PER_W'(MAX_PERIOD);

    shape_t             shape_reg;
    logic [AMP_W-1:0]   amplitude_reg;
    logic [PER_W-1:0]   period_reg;

    logic [PER_W-1:0]   n_eff;
    logic [AMP_W-2:0]   half_amp;

    logic [NSTG-1:0]    v_reg;
    logic [NSTG-1:0]    v_next;
    logic [NSTG-1:0]    en;
    stage_t             st_reg [NSTG];
    stage_t             st_next [NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg     <= SHAPE_SINE;
            amplitude_reg <= AMP_RESET;
            period_reg    <= PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SHAPE:     shape_reg     <= shape_t'(cfg_data[1:0]);
                REG_AMPLITUDE: amplitude_reg <= cfg_data[AMP_W-1:0];
                REG_PERIOD:    period_reg    <= cfg_data[PER_W-1:0];
                default:       ;
            endcase
        end
    end

    assign n_eff    = (32'(period_reg) > MAX_PERIOD) ? PERIOD_CAP : period_reg;
    assign half_amp = amplitude_reg[AMP_W-1:1];

    // a stage advances when it is empty or everything after it can move
    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            en[k] = !result_stall ||
                    ((v_reg | NSTG'((64'd1 << k) - 64'd1)) != {NSTG{1'b1}});
        end
    end

    assign sample_stall = !en[0];
    assign v_next       = {v_reg[NSTG-2:0], sample_valid};

    always_comb
    begin
        stage_t                  s;
        logic [IDX_W+AMP_W-1:0]  ai;
        logic [NUM_W-1:0]        num;
        logic [REM_W:0]          r13;
        logic [QUO_W-1:0]        phase;
        logic [T_W-1:0]          a;
        logic [T2_W-1:0]         sv;
        logic [T2_W:0]           rnd;
        logic [MAG_W-1:0]        mag;
        logic signed [OPD_W-1:0] opd;
        logic signed [HM_W-1:0]  ha_s;
        logic signed [HM_W-1:0]  opd_s;
        logic signed [SV_W-1:0]  v;
        logic [LIN_W-1:0]        code13;
        logic [CODE_W-1:0]       full;

        // entry: range check and divider numerator
        s   = '0;
        ai  = (IDX_W+AMP_W)'(amplitude_reg) * (IDX_W+AMP_W)'(sample_index);
        unique case (shape_reg)
            SHAPE_SINE, SHAPE_HAVERSINE: num = {sample_index, {QUO_W{1'b0}}};
            SHAPE_TRIANGLE:              num = NUM_W'({ai, 1'b0});
            SHAPE_SAWTOOTH:              num = NUM_W'(ai);
            default:                     num = '0;
        endcase
        s.idx = sample_index;
        s.oor = (n_eff == '0) || ({1'b0, sample_index} >= n_eff);
        s.rem = REM_W'(num[NUM_W-1:QUO_W]);
        s.low = num[QUO_W-1:0];
        st_next[0] = s;

        // restoring divider, quotient bits shift in as numerator bits leave
        for (int d = 1; d <= DIV_STAGES; d++)
        begin
            s = st_reg[d-1];
            for (int b = 0; b < DIV_STEPS; b++)
            begin
                r13 = {s.rem, s.low[QUO_W-1]};
                if (r13 >= {1'b0, n_eff})
                begin
                    s.rem = REM_W'(r13 - {1'b0, n_eff});
                    s.low = {s.low[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    s.rem = r13[REM_W-1:0];
                    s.low = {s.low[QUO_W-2:0], 1'b0};
                end
            end
            st_next[d] = s;
        end

        // quadrant fold of the phase, linear shapes finish here
        s     = st_reg[ST_PHASE-1];
        phase = (shape_reg == SHAPE_HAVERSINE) ? s.low + QUARTER_TURN : s.low;
        s.neg = phase[QUO_W-1];
        s.r   = phase[QUO_W-2] ? R_W'(QUARTER_TURN) - {1'b0, phase[QUO_W-3:0]}
                               : {1'b0, phase[QUO_W-3:0]};
        unique case (shape_reg)
            SHAPE_TRIANGLE:
                s.lin = ({1'b0, s.idx} < (n_eff >> 1)) ? s.low[LIN_W-1:0]
                        : {amplitude_reg, 1'b0} - s.low[LIN_W-1:0];
            SHAPE_SAWTOOTH:
                s.lin = s.low[LIN_W-1:0];
            default:
                s.lin = '0;
        endcase
        st_next[ST_PHASE] = s;

        // angle in q1.30
        s   = st_reg[ST_T-1];
        s.t = T_W'(((R_W+T_W)'(s.r) * (R_W+T_W)'(HALF_PI_Q30)) >> 22);
        st_next[ST_T] = s;

        s    = st_reg[ST_T2-1];
        s.t2 = T2_W'(((2*T_W)'(s.t) * (2*T_W)'(s.t)) >> 30);
        st_next[ST_T2] = s;

        s   = st_reg[ST_P0-1];
        s.p = P_W'(s.t2 >> STEP_SHIFT[0]) * P_W'(STEP_M[0]);
        st_next[ST_P0] = s;

        // horner steps of the odd series
        for (int j = 1; j < SERIES_TERMS; j++)
        begin
            s   = st_reg[ST_P0 + 2*j - 2];
            a   = Q30_ONE - T_W'(s.p >> STEP_K[j-1]);
            s.y = T2_W'(((T2_W+T_W)'(s.t2) * (T2_W+T_W)'(a)) >> 30);
            st_next[ST_P0 + 2*j - 1] = s;

            s   = st_reg[ST_P0 + 2*j - 1];
            s.p = P_W'(s.y >> STEP_SHIFT[j]) * P_W'(STEP_M[j]);
            st_next[ST_P0 + 2*j] = s;
        end

        s   = st_reg[ST_PROD-1];
        a   = Q30_ONE - T_W'(s.p >> STEP_K[SERIES_TERMS-1]);
        s.p = P_W'(s.t) * P_W'(a);
        st_next[ST_PROD] = s;

        // round to q1.15, clamp at one, apply quadrant sign
        s   = st_reg[ST_ROUND-1];
        sv  = T2_W'(s.p >> 30);
        rnd = ({1'b0, sv} + ROUND_HALF) >> 15;
        mag = (rnd > (T2_W+1)'(ONE_Q15)) ? ONE_Q15 : MAG_W'(rnd);
        s.m = s.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        st_next[ST_ROUND] = s;

        s     = st_reg[ST_MUL-1];
        opd   = (shape_reg == SHAPE_HAVERSINE) ? $signed({1'b0, ONE_Q15}) - s.m : s.m;
        ha_s  = HM_W'($signed({1'b0, half_amp}));
        opd_s = HM_W'(opd);
        s.hm  = ha_s * opd_s;
        st_next[ST_MUL] = s;

        s = st_reg[ST_OUT-1];
        v = MIDPOINT_Q15 + SV_W'(s.hm);
        unique case (shape_reg)
            SHAPE_SINE:      code13 = LIN_W'(v[SV_W-1:15]);
            SHAPE_HAVERSINE: code13 = MIDPOINT + LIN_W'(s.hm[HM_W-1:16]);
            SHAPE_TRIANGLE,
            SHAPE_SAWTOOTH:  code13 = s.lin;
            default:         code13 = '0;
        endcase
        full = CODE_W'(code13);
        if (s.oor)
            s.code = '0;
        else if (full > DAC_MAX)
            s.code = DAC_MAX;
        else
            s.code = full;
        st_next[ST_OUT] = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (en[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign result_valid       = v_reg[ST_OUT];
    assign dac_code           = st_reg[ST_OUT].code[DAC_BITS-1:0];
    assign index_out_of_range = st_reg[ST_OUT].oor;

endmodule

@@ hw/rtl/wtsg_assert_checker.sv @@
// port-level checks for the waveform table sample generator, bound to the top level
// depends on waveform_table_sample_generator_unit_assert.svh
`include "waveform_table_sample_generator_unit_assert.svh"

module wtsg_assert_checker #(
    parameter int DAC_BITS = 12
) (
    input logic                clk,
    input logic                rst_n,
    input logic                sample_valid,
    input logic                sample_stall,
    input logic                result_valid,
    input logic                result_stall,
    input logic [DAC_BITS-1:0] dac_code,
    input logic                index_out_of_range
);

    // a held result keeps its payload
    `WTSG_ASSERT_NEXT(result_hold, result_valid && result_stall, result_valid && $stable(dac_code) && $stable(index_out_of_range))

    // out of range requests always read as code zero
    `WTSG_ASSERT_SAME(range_flag_zero_code, result_valid && index_out_of_range, dac_code == '0)

    // input side only backs up once the result side is blocked
    `WTSG_ASSERT_SAME(stall_only_when_full, sample_stall, result_valid && result_stall)

    // an empty output with a request waiting never stalls the input
    `WTSG_ASSERT_SAME(no_stall_when_out_empty, sample_valid && !result_valid, !sample_stall)

endmodule

bind waveform_table_sample_generator_unit wtsg_assert_checker #(
    .DAC_BITS(DAC_BITS)
) u_wtsg_assert_checker (.*);
